// ----- rtl/core/hcpg_pkg.sv -----
// Shared types, constants and helper functions for the Hilbert curve point generator.
package hcpg_pkg;

  localparam int MaxOrder   = 16;
  localparam int OrderW     = 5;
  localparam int DepthW     = $clog2(MaxOrder);
  localparam int CoordW     = 16;
  localparam int IndexW     = 32;
  localparam int HeadW      = 2;
  localparam int PhaseW     = 2;

  localparam logic [OrderW-1:0] OrderReset = 5'd1;

  // heading codes
  localparam logic [HeadW-1:0] HeadPosI = 2'd0;
  localparam logic [HeadW-1:0] HeadPosJ = 2'd1;
  localparam logic [HeadW-1:0] HeadNegI = 2'd2;
  localparam logic [HeadW-1:0] HeadNegJ = 2'd3;

  // per-level phase codes
  localparam logic [PhaseW-1:0] PhaseFirst  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseSecond = 2'd1;
  localparam logic [PhaseW-1:0] PhaseThird  = 2'd2;
  localparam logic [PhaseW-1:0] PhaseLast   = 2'd3;

  typedef struct packed {
    logic start;      // clear turtle, begin descent from level 0
    logic desc_step;  // push one level
    logic desc_end;   // descent finished, set cursor depth
    logic walk;       // act on the level at the cursor
    logic load_out;   // capture the point into the output register
  } hcpg_cmd_t;

  typedef struct packed {
    logic running;
    logic at_last;    // current point is the last of the curve
    logic desc_done;  // descent counter reached the order
    logic walk_wrap;  // top level exhausted
    logic walk_desc;  // walk step moved, descend follows
  } hcpg_status_t;

  // Register bits to the order actually used (1..MaxOrder).
  function automatic logic [OrderW-1:0] eff_order(input logic [OrderW-1:0] order_reg);
    logic [OrderW-1:0] o;
    o = order_reg;
    if (o == '0) o = OrderW'(1);
    if (o > OrderW'(MaxOrder)) o = OrderW'(MaxOrder);
    return o;
  endfunction

  // 4^order - 1 as a bit mask of 2*order ones.
  function automatic logic [IndexW-1:0] last_index(input logic [OrderW-1:0] order);
    logic [IndexW-1:0] m;
    logic [OrderW:0]   twice;
    twice = {order, 1'b0};
    for (int b = 0; b < IndexW; b++) begin
      m[b] = ((OrderW+1)'(b) < twice);
    end
    return m;
  endfunction

  // +90 degrees in the level's orientation
  function automatic logic [HeadW-1:0] turn_plus(input logic [HeadW-1:0] h, input logic f);
    return h + (f ? HeadW'(3) : HeadW'(1));
  endfunction

  // -90 degrees in the level's orientation
  function automatic logic [HeadW-1:0] turn_minus(input logic [HeadW-1:0] h, input logic f);
    return h + (f ? HeadW'(1) : HeadW'(3));
  endfunction

endpackage

// ----- rtl/core/hcpg_req_if.sv -----
// Request channel: valid/ready handshake carrying the restart flag.
interface hcpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- rtl/core/hcpg_pnt_if.sv -----
// Point channel: valid/ready handshake carrying one curve point.
interface hcpg_pnt_if
  import hcpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] coord_i;
  logic [CoordW-1:0] coord_j;
  logic [IndexW-1:0] point_index;
  logic              last_point;

  modport source (output valid, output coord_i, output coord_j, output point_index,
                  output last_point, input ready);
  modport sink   (input valid, input coord_i, input coord_j, input point_index,
                  input last_point, output ready);
endinterface

// ----- rtl/core/hilbert_curve_point_generator_top.sv -----
// Top level of the Hilbert curve point generator: controller, datapath and channels.
//
// Emits the points of a Hilbert curve over a 2^order by 2^order grid, one point
// per request transaction, starting at (0,0). A request with restart set begins
// again at point 0; otherwise it yields the next point, and point_index counts
// along the curve with last_point marking point 4^order - 1. A request after
// the last point, or the first request after reset or after an order write,
// starts a fresh curve. The user must see that curve_order is written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// 0 acts as 1 and values above 16 act as 16. One request is worked at a time.
// A restart clears the turtle in the accepting cycle, pushes the stack levels
// one by one, closes the descent and loads the output register. An advance
// unwinds the exhausted levels (0..order-1 of them, none on three steps in four),
// moves the turtle, pushes the unwound levels again, closes the descent and
// loads the output register. The controller walks the level stack one level
// per cycle. The output register lets the next request be taken while a point
// waits to be collected.
module hilbert_curve_point_generator_top
  import hcpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [OrderW-1:0] cfg_wdata,
  hcpg_req_if.sink          request,
  hcpg_pnt_if.source        point
);

  hcpg_cmd_t    cmd;
  hcpg_status_t status;

  // sequencing and handshakes
  hcpg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (request.valid),
    .req_restart (request.restart),
    .req_ready   (request.ready),
    .pnt_valid   (point.valid),
    .pnt_ready   (point.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // turtle, level stack and output register
  hcpg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .coord_i     (point.coord_i),
    .coord_j     (point.coord_j),
    .point_index (point.point_index),
    .last_point  (point.last_point)
  );

endmodule

// ----- rtl/core/hcpg_datapath.sv -----
// Datapath: turtle position and heading, level stack, order register, output register.
module hcpg_datapath
  import hcpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [OrderW-1:0] cfg_wdata,
  input  hcpg_cmd_t         cmd,
  output hcpg_status_t      status,
  output logic [CoordW-1:0] coord_i,
  output logic [CoordW-1:0] coord_j,
  output logic [IndexW-1:0] point_index,
  output logic              last_point
);

  logic [OrderW-1:0] curve_order;
  logic              running;
  logic [HeadW-1:0]  heading;
  logic [CoordW-1:0] pos_i;
  logic [CoordW-1:0] pos_j;
  logic [IndexW-1:0] count;
  logic [DepthW-1:0] depth;
  logic [OrderW-1:0] dd;     // descent level counter, reaches the order itself
  logic              fcur;   // orientation of the level being pushed
  logic [PhaseW-1:0] level_phase [MaxOrder];
  logic              level_flip  [MaxOrder];

  logic [HeadW-1:0]  heading_next;
  logic [CoordW-1:0] pos_i_next;
  logic [CoordW-1:0] pos_j_next;
  logic [IndexW-1:0] count_next;
  logic [DepthW-1:0] depth_next;
  logic [OrderW-1:0] dd_next;
  logic              fcur_next;
  logic              ph_we;
  logic [DepthW-1:0] ph_addr;
  logic [PhaseW-1:0] ph_data;
  logic              fl_we;

  logic [OrderW-1:0] order;
  logic [PhaseW-1:0] cur_p;
  logic              cur_f;
  logic              mv_en;
  logic [HeadW-1:0]  mv_head;

  assign order = eff_order(curve_order);
  assign cur_p = level_phase[depth];
  assign cur_f = level_flip[depth];

  assign status.running   = running;
  assign status.at_last   = (count == last_index(order));
  assign status.desc_done = (dd == order);
  assign status.walk_wrap = (cur_p == PhaseLast) && (depth == '0);
  assign status.walk_desc = (cur_p != PhaseLast);

  always_comb begin
    heading_next = heading;
    pos_i_next   = pos_i;
    pos_j_next   = pos_j;
    count_next   = count;
    depth_next   = depth;
    dd_next      = dd;
    fcur_next    = fcur;
    ph_we        = 1'b0;
    ph_addr      = dd[DepthW-1:0];
    ph_data      = PhaseFirst;
    fl_we        = 1'b0;
    mv_en        = 1'b0;
    mv_head      = heading;

    if (cmd.start) begin
      heading_next = HeadPosI;
      pos_i_next   = '0;
      pos_j_next   = '0;
      count_next   = '0;
      dd_next      = '0;
      fcur_next    = 1'b0;
    end else if (cmd.desc_step) begin
      ph_we        = 1'b1;
      fl_we        = 1'b1;
      heading_next = turn_plus(heading, fcur);
      fcur_next    = ~fcur;
      dd_next      = dd + OrderW'(1);
    end else if (cmd.desc_end) begin
      depth_next = DepthW'(order - OrderW'(1));
    end else if (cmd.walk) begin
      ph_addr = depth;
      ph_data = cur_p + PhaseW'(1);
      dd_next = {1'b0, depth} + OrderW'(1);
      case (cur_p)
        PhaseFirst: begin
          mv_en        = 1'b1;
          heading_next = turn_minus(heading, cur_f);
          ph_we        = 1'b1;
          fcur_next    = cur_f;
        end
        PhaseSecond: begin
          mv_en     = 1'b1;
          ph_we     = 1'b1;
          fcur_next = cur_f;
        end
        PhaseThird: begin
          mv_head      = turn_minus(heading, cur_f);
          heading_next = mv_head;
          mv_en        = 1'b1;
          ph_we        = 1'b1;
          fcur_next    = ~cur_f;
        end
        default: begin
          heading_next = turn_plus(heading, cur_f);
          depth_next   = depth - DepthW'(1);
        end
      endcase
    end

    if (mv_en) begin
      count_next = count + IndexW'(1);
      case (mv_head)
        HeadPosI: pos_i_next = pos_i + CoordW'(1);
        HeadPosJ: pos_j_next = pos_j + CoordW'(1);
        HeadNegI: pos_i_next = pos_i - CoordW'(1);
        default:  pos_j_next = pos_j - CoordW'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= OrderReset;
      running     <= 1'b0;
      heading     <= HeadPosI;
      pos_i       <= '0;
      pos_j       <= '0;
      count       <= '0;
      depth       <= '0;
      dd          <= '0;
      fcur        <= 1'b0;
      for (int k = 0; k < MaxOrder; k++) begin
        level_phase[k] <= PhaseFirst;
        level_flip[k]  <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        curve_order <= cfg_wdata;
        running     <= 1'b0;
      end else if (cmd.start) begin
        running <= 1'b1;
      end
      heading <= heading_next;
      pos_i   <= pos_i_next;
      pos_j   <= pos_j_next;
      count   <= count_next;
      depth   <= depth_next;
      dd      <= dd_next;
      fcur    <= fcur_next;
      if (ph_we) level_phase[ph_addr] <= ph_data;
      if (fl_we) level_flip[ph_addr] <= fcur;
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      coord_i     <= pos_i;
      coord_j     <= pos_j;
      point_index <= count;
      last_point  <= status.at_last;
    end
  end

endmodule

// ----- rtl/core/hcpg_ctrl.sv -----
// Controller: sequences restart, stack walk and descent, owns the handshakes.
module hcpg_ctrl
  import hcpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_restart,
  output logic         req_ready,
  output logic         pnt_valid,
  input  logic         pnt_ready,
  input  hcpg_status_t status,
  output hcpg_cmd_t    cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDesc = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       pnt_valid_next;
  logic       accept;

  assign req_ready = (state == StIdle);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    pnt_valid_next = pnt_valid && !pnt_ready;
    case (state)
      StIdle: begin
        if (accept) begin
          if (req_restart || !status.running || status.at_last) begin
            cmd.start  = 1'b1;
            state_next = StDesc;
          end else begin
            state_next = StWalk;
          end
        end
      end
      StDesc: begin
        if (status.desc_done) begin
          cmd.desc_end = 1'b1;
          state_next   = StEmit;
        end else begin
          cmd.desc_step = 1'b1;
        end
      end
      StWalk: begin
        if (status.walk_wrap) begin
          cmd.start  = 1'b1;
          state_next = StDesc;
        end else begin
          cmd.walk = 1'b1;
          if (status.walk_desc) state_next = StDesc;
        end
      end
      default: begin
        if (!pnt_valid || pnt_ready) begin
          cmd.load_out   = 1'b1;
          pnt_valid_next = 1'b1;
          state_next     = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      pnt_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pnt_valid <= pnt_valid_next;
    end
  end

endmodule

// ----- bench/tb_hilbert_curve_point_generator_top.sv -----
// Self-checking bench for the Hilbert curve point generator: random handshakes, order sweeps.
module tb_hilbert_curve_point_generator_top;
  import hcpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;   // receiver hold-off, long enough to back the block up
  localparam int SettleWait = 40;    // a little over the deepest carry

  // quarter turns of the heading, counter-clockwise and clockwise
  localparam logic [1:0] TurnLeft  = 2'd1;
  localparam logic [1:0] TurnRight = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] coord_i;
    logic [CoordW-1:0] coord_j;
    logic [IndexW-1:0] point_index;
    logic              last_point;
  } point_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [OrderW-1:0] cfg_wdata;

  hcpg_req_if request_ch ();
  hcpg_pnt_if point_ch ();

  hilbert_curve_point_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request_ch.sink),
    .point     (point_ch.source)
  );

  // ---------------------------------------------------------------------------
  // Curve walker: own copy of the turtle, the level stack and the order register
  // ---------------------------------------------------------------------------
  logic [OrderW-1:0] order_bits;
  logic [1:0]        turtle_dir;
  logic [CoordW-1:0] turtle_i;
  logic [CoordW-1:0] turtle_j;
  logic [IndexW-1:0] walked;
  logic [1:0]        lvl_stage [MaxOrder];
  logic              lvl_mirror [MaxOrder];
  bit                curve_live;
  int                cur_level;

  // register bits to the depth actually walked
  function automatic int order_span();
    int s;
    s = int'(order_bits);
    if (s < 1) s = 1;
    if (s > MaxOrder) s = MaxOrder;
    return s;
  endfunction

  function automatic logic [IndexW-1:0] final_index(input int span);
    logic [63:0] full;
    full = (64'd1 << (2 * span)) - 64'd1;
    return full[IndexW-1:0];
  endfunction

  // ccw = 1 turns +90 in the level's sense, a mirrored level turns the other way
  task automatic quarter_turn(input logic mirror, input logic ccw);
    turtle_dir = turtle_dir + ((ccw ^ mirror) ? TurnLeft : TurnRight);
  endtask

  task automatic step_forward();
    case (turtle_dir)
      HeadPosI: turtle_i = turtle_i + CoordW'(1);
      HeadPosJ: turtle_j = turtle_j + CoordW'(1);
      HeadNegI: turtle_i = turtle_i - CoordW'(1);
      default:  turtle_j = turtle_j - CoordW'(1);
    endcase
    walked = walked + IndexW'(1);
  endtask

  // push fresh levels from depth d down to the bottom of the curve
  task automatic push_levels(input int d, input logic mirror, input int span);
    while (d < span) begin
      lvl_stage[d]  = PhaseFirst;
      lvl_mirror[d] = mirror;
      quarter_turn(mirror, 1'b1);
      mirror = ~mirror;
      d++;
    end
    cur_level = span - 1;
  endtask

  task automatic begin_curve(input int span);
    turtle_dir = HeadPosI;
    turtle_i   = '0;
    turtle_j   = '0;
    walked     = '0;
    curve_live = 1'b1;
    push_levels(0, 1'b0, span);
  endtask

  // one request in, the point it should produce out
  task automatic hilbert_next(input logic restart, output point_t pt);
    int   span;
    int   d;
    logic m;
    bit   moved;
    span = order_span();
    if (restart || !curve_live || walked == final_index(span)) begin
      begin_curve(span);
    end else begin
      moved = 1'b0;
      while (!moved) begin
        d = cur_level % MaxOrder;
        m = lvl_mirror[d];
        case (lvl_stage[d])
          PhaseFirst: begin
            step_forward();
            lvl_stage[d] = PhaseSecond;
            quarter_turn(m, 1'b0);
            push_levels(d + 1, m, span);
            moved = 1'b1;
          end
          PhaseSecond: begin
            step_forward();
            lvl_stage[d] = PhaseThird;
            push_levels(d + 1, m, span);
            moved = 1'b1;
          end
          PhaseThird: begin
            quarter_turn(m, 1'b0);
            step_forward();
            lvl_stage[d] = PhaseLast;
            push_levels(d + 1, ~m, span);
            moved = 1'b1;
          end
          default: begin
            // level exhausted: unwind, or wrap when the top level is done
            quarter_turn(m, 1'b1);
            if (d == 0) begin
              begin_curve(span);
              moved = 1'b1;
            end else begin
              cur_level = d - 1;
            end
          end
        endcase
      end
    end
    pt.coord_i     = turtle_i;
    pt.coord_j     = turtle_j;
    pt.point_index = walked;
    pt.last_point  = (walked == final_index(span));
  endtask

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  bit     request_queue[$];   // restart flags still to be offered
  point_t expected_points[$]; // points owed by the block, oldest first
  point_t want_pt;
  point_t got_pt;
  point_t next_pt;

  int     src_gap;
  int     sink_gap;
  int     hold_left;
  bit     hold_started;
  bit     long_hold_go;
  bit     src_idle_on;
  bit     sink_idle_on;

  int     error_count;
  int     requests_taken;
  int     restarts_taken;
  int     points_checked;
  int     curve_ends;
  int     order_settings;
  int     cycle_count;

  // clock and the single reset pulse
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout at %0t after %0d cycles, %0d points still owed",
               $time, cycle_count, expected_points.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: keeps valid up until the transaction is taken, then either
  // offers the next queued item or sits out an idle burst
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      request_ch.valid   <= 1'b0;
      request_ch.restart <= 1'b0;
      src_gap            <= 0;
    end else if (!request_ch.valid || request_ch.ready) begin
      if (src_gap != 0) begin
        request_ch.valid <= 1'b0;
        src_gap          <= src_gap - 1;
      end else if (request_queue.size() != 0) begin
        request_ch.valid   <= 1'b1;
        request_ch.restart <= request_queue.pop_front();
        // idle burst after this transaction goes through
        if (src_idle_on && $urandom_range(0, 4) == 0)
          src_gap <= $urandom_range(1, 6);
      end else begin
        request_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point receiver: random stalls in bursts, plus one long hold-off that it
  // times itself once asked, so that the block backs up and stops taking requests
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      point_ch.ready <= 1'b0;
      sink_gap       <= 0;
      hold_left      <= 0;
      hold_started   <= 1'b0;
    end else if (long_hold_go && !hold_started) begin
      hold_started   <= 1'b1;
      hold_left      <= LongHold;
      point_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      point_ch.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap       <= sink_gap - 1;
      point_ch.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
      sink_gap       <= $urandom_range(0, 5);  // random burst of stalls
      point_ch.ready <= 1'b0;
    end else begin
      point_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each point transaction against the oldest owed point, then
  // works out the point owed for any request taken at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (point_ch.valid && point_ch.ready) begin
        got_pt.coord_i     = point_ch.coord_i;
        got_pt.coord_j     = point_ch.coord_j;
        got_pt.point_index = point_ch.point_index;
        got_pt.last_point  = point_ch.last_point;
        if (expected_points.size() == 0) begin
          $display("%0t: point with nothing owed: i=%0d j=%0d index=%0d last=%0b",
                   $time, got_pt.coord_i, got_pt.coord_j, got_pt.point_index,
                   got_pt.last_point);
          error_count++;
        end else begin
          want_pt = expected_points.pop_front();
          points_checked++;
          if (got_pt.last_point) curve_ends++;
          if (got_pt.coord_i !== want_pt.coord_i) begin
            $display("%0t: coord_i expected %0d actual %0d", $time,
                     want_pt.coord_i, got_pt.coord_i);
            error_count++;
          end
          if (got_pt.coord_j !== want_pt.coord_j) begin
            $display("%0t: coord_j expected %0d actual %0d", $time,
                     want_pt.coord_j, got_pt.coord_j);
            error_count++;
          end
          if (got_pt.point_index !== want_pt.point_index) begin
            $display("%0t: point_index expected %0d actual %0d", $time,
                     want_pt.point_index, got_pt.point_index);
            error_count++;
          end
          if (got_pt.last_point !== want_pt.last_point) begin
            $display("%0t: last_point expected %0b actual %0b", $time,
                     want_pt.last_point, got_pt.last_point);
            error_count++;
          end
        end
      end
      if (request_ch.valid && request_ch.ready) begin
        hilbert_next(request_ch.restart, next_pt);
        expected_points.push_back(next_pt);
        requests_taken++;
        if (request_ch.restart) restarts_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // random phases: order written (extremes and out-of-range included) and length
  int unsigned phase_order [16] = '{2, 3, 1, 4, 5, 16, 0, 31, 3, 8, 2, 6, 17, 12, 3, 2};
  int unsigned phase_len   [16] = '{40, 70, 20, 60, 30, 25, 15, 20, 70, 30, 40, 30, 20,
                                    25, 40, 25};

  task automatic offer(input bit restart);
    request_queue.push_back(restart);
  endtask

  // wait until every offered transaction has gone in and every point come out
  task automatic drain();
    do @(negedge clk);
    while (request_queue.size() != 0 || request_ch.valid || expected_points.size() != 0);
  endtask

  // order write while idle; the walker forgets its sequence just as the block does
  task automatic write_order(input logic [OrderW-1:0] value);
    @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    order_bits  = value;
    curve_live  = 1'b0;
    order_settings++;
  endtask

  initial begin
    int k;
    int n;
    // known levels on every input from time zero
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    request_ch.valid   = 1'b0;
    request_ch.restart = 1'b0;
    point_ch.ready     = 1'b0;
    src_idle_on        = 1'b1;
    sink_idle_on       = 1'b1;
    long_hold_go       = 1'b0;
    cycle_count        = 0;
    src_gap            = 0;
    sink_gap           = 0;
    hold_left          = 0;

    // walker reset state; order comes up at its reset value
    order_bits = OrderReset;
    turtle_dir = HeadPosI;
    turtle_i   = '0;
    turtle_j   = '0;
    walked     = '0;
    curve_live = 1'b0;
    cur_level  = 0;
    for (k = 0; k < MaxOrder; k++) begin
      lvl_stage[k]  = PhaseFirst;
      lvl_mirror[k] = 1'b0;
    end

    @(negedge rst);

    // reset order: advance before any start, full curve, wrap, restart mid-curve
    offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b1);
    offer(1'b0);
    drain();

    // order 0 behaves as 1, including the wrap after the last point
    write_order(5'd0);
    offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b0);
    drain();

    // top of the register range clamps to the deepest curve
    write_order(5'd31);
    offer(1'b0); offer(1'b0); offer(1'b1);
    drain();

    write_order(5'd16);
    offer(1'b1); offer(1'b0); offer(1'b0);
    drain();

    // order 2: restart in the middle of a curve
    write_order(5'd2);
    offer(1'b0); offer(1'b0); offer(1'b0); offer(1'b1); offer(1'b0); offer(1'b0);
    offer(1'b0);
    drain();

    // random part: mostly plain advances so the curves run deep and wrap,
    // with the odd restart thrown in
    for (k = 0; k < 16; k++) begin
      src_idle_on  = (k != 6) && (k < 13);   // a quiet stretch, and none at the end
      sink_idle_on = (k != 6) && (k < 13);
      write_order(phase_order[k][OrderW-1:0]);
      if (k == 3) long_hold_go = 1'b1;
      for (n = 0; n < int'(phase_len[k]); n++)
        offer($urandom_range(0, 23) == 0);
      drain();
    end

    repeat (SettleWait) @(posedge clk);

    $display("Ran %0d request transactions (%0d restarts) over %0d order settings,",
             requests_taken, restarts_taken, order_settings);
    $display("checked %0d points, %0d of them curve ends, %0d mismatches",
             points_checked, curve_ends, error_count);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
